FILE: hw/rtl/otm_pkg.sv
// ----------------------------------------------------------------------------
// Overcurrent trip monitor package
// Shared constants, register indexes and the trip-stage configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package otm_pkg;

  // Default widths of the sample and of the violation counter.
  localparam int ADC_BITS_DEF   = 10;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed register widths.
  localparam int ALPHA_BITS     = 13;
  localparam int LIMIT_BITS     = 19;
  localparam int THRESH_BITS    = 16;
  localparam int CFG_DATA_BITS  = 19;
  localparam int CFG_INDEX_BITS = 2;

  // The filter weight is Q1.12, so one is 4096.
  localparam int ALPHA_FRAC = 12;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 13'd4096;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_ALPHA   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURRENT_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIP_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET     = 13'd410;
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET     = 19'd186670;
  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 16'd150;

  // Settings used by the trip stage.
  typedef struct packed {
    logic [LIMIT_BITS-1:0]  limit;
    logic [THRESH_BITS-1:0] threshold;
  } trip_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/overcurrent_trip_monitor.sv
// ----------------------------------------------------------------------------
// Overcurrent trip monitor
// Two-channel exponential current filter with an up/down violation counter
// and a latched shutdown request.
// ----------------------------------------------------------------------------
// Pipeline: the input register loads at the accepting edge, then the filter
// stage and the trip stage follow, each with its own registered valid.
// Throughput: one sample pair per cycle; each stage holds one item and
// stalls only when the stage after it is full and the output is not taken.
// Reset clears the filter levels, the violation counter, the shutdown flag
// and the pipeline valids, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module overcurrent_trip_monitor #(
  parameter int ADC_BITS   = otm_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = otm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic [otm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [otm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // Input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [ADC_BITS-1:0]                  sample_left,
  input  wire logic [ADC_BITS-1:0]                  sample_right,
  // Output channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [ADC_BITS+7:0]                  filtered_left,
  output logic      [ADC_BITS+7:0]                  filtered_right,
  output logic                                      over_limit,
  output logic      [COUNT_BITS-1:0]                violation_count,
  output logic                                      shutdown
);

  localparam int LW = ADC_BITS + 8;

  logic [otm_pkg::ALPHA_BITS-1:0]  filter_alpha;
  logic [otm_pkg::LIMIT_BITS-1:0]  current_limit;
  logic [otm_pkg::THRESH_BITS-1:0] trip_threshold;
  logic [otm_pkg::ALPHA_BITS-1:0]  alpha_eff;
  otm_pkg::trip_cfg_t              trip_cfg;

  logic                in_vld;
  logic                lvl_vld;
  logic                res_vld;
  logic                in_rdy;
  logic                lvl_rdy;
  logic                res_rdy;
  logic                in_load;
  logic                lvl_load;
  logic                res_load;
  logic [ADC_BITS-1:0] samp_left;
  logic [ADC_BITS-1:0] samp_right;
  logic [LW-1:0]       level_left;
  logic [LW-1:0]       level_right;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha   <= otm_pkg::ALPHA_RESET;
      current_limit  <= otm_pkg::LIMIT_RESET;
      trip_threshold <= otm_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        otm_pkg::REG_FILTER_ALPHA: begin
          filter_alpha <= cfg_data[otm_pkg::ALPHA_BITS-1:0];
        end
        otm_pkg::REG_CURRENT_LIMIT: begin
          current_limit <= cfg_data[otm_pkg::LIMIT_BITS-1:0];
        end
        otm_pkg::REG_TRIP_THRESHOLD: begin
          trip_threshold <= cfg_data[otm_pkg::THRESH_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A weight above one acts as one.
  always_comb begin
    alpha_eff = (filter_alpha > otm_pkg::ALPHA_ONE) ? otm_pkg::ALPHA_ONE
                                                    : filter_alpha;
    trip_cfg.limit     = current_limit;
    trip_cfg.threshold = trip_threshold;
  end

  // Pipeline flow control: a stage takes a new item when it is empty or
  // its current item moves on in the same cycle.
  always_comb begin
    res_rdy  = !res_vld || out_ready;
    lvl_rdy  = !lvl_vld || res_rdy;
    in_rdy   = !in_vld  || lvl_rdy;
    in_load  = in_valid && in_rdy;
    lvl_load = in_vld   && lvl_rdy;
    res_load = lvl_vld  && res_rdy;
  end

  assign in_ready  = in_rdy;
  assign out_valid = res_vld;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      lvl_vld <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld <= in_valid;
      end
      if (lvl_rdy) begin
        lvl_vld <= in_vld;
      end
      if (res_rdy) begin
        res_vld <= lvl_vld;
      end
    end
  end

  // Input sample register.
  always_ff @(posedge clk) begin
    if (in_load) begin
      samp_left  <= sample_left;
      samp_right <= sample_right;
    end
  end

  // Filter stage, one per channel.
  otm_ema #(
    .ADC_BITS (ADC_BITS)
  ) u_ema_left (
    .clk    (clk),
    .rst    (rst),
    .load   (lvl_load),
    .sample (samp_left),
    .alpha  (alpha_eff),
    .level  (level_left)
  );

  otm_ema #(
    .ADC_BITS (ADC_BITS)
  ) u_ema_right (
    .clk    (clk),
    .rst    (rst),
    .load   (lvl_load),
    .sample (samp_right),
    .alpha  (alpha_eff),
    .level  (level_right)
  );

  // Trip stage and result register.
  otm_trip #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_trip (
    .clk             (clk),
    .rst             (rst),
    .load            (res_load),
    .level_left      (level_left),
    .level_right     (level_right),
    .cfg             (trip_cfg),
    .filtered_left   (filtered_left),
    .filtered_right  (filtered_right),
    .over_limit      (over_limit),
    .violation_count (violation_count),
    .shutdown        (shutdown)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/otm_ema.sv
// ----------------------------------------------------------------------------
// Exponential low-pass filter, one channel
// Holds the filtered level and updates it with one sample per load.
// ----------------------------------------------------------------------------
`default_nettype none

module otm_ema #(
  parameter int ADC_BITS = otm_pkg::ADC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire logic [ADC_BITS-1:0]               sample,
  input  wire logic [otm_pkg::ALPHA_BITS-1:0]    alpha,
  output logic      [ADC_BITS+7:0]               level
);

  localparam int LW = ADC_BITS + 8;
  localparam int DW = LW + 1;
  localparam int PW = DW + otm_pkg::ALPHA_BITS + 1;

  logic signed [DW-1:0]                    diff;
  logic signed [otm_pkg::ALPHA_BITS:0]     alpha_s;
  logic signed [PW-1:0]                    prod;
  logic signed [PW-1:0]                    delta;
  logic signed [PW-1:0]                    level_sum;
  logic        [LW-1:0]                    level_next;

  // The update old*(1-a) + s*a equals old + floor((s - old) * a), which
  // needs a single signed multiplier.
  always_comb begin
    diff       = $signed({1'b0, sample, 8'b0}) - $signed({1'b0, level});
    alpha_s    = $signed({1'b0, alpha});
    prod       = diff * alpha_s;
    delta      = prod >>> otm_pkg::ALPHA_FRAC;
    level_sum  = delta + $signed({{(PW-LW){1'b0}}, level});
    level_next = level_sum[LW-1:0];
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (load) begin
      level <= level_next;
    end
  end

  // The level moves only when a sample is taken in.
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(level))
    else $error("filter level changed without a sample");

endmodule

`default_nettype wire

FILE: hw/rtl/otm_trip.sv
// ----------------------------------------------------------------------------
// Trip stage
// Compares the summed levels with the limit, runs the up/down violation
// counter, latches shutdown and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module otm_trip #(
  parameter int ADC_BITS   = otm_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = otm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [ADC_BITS+7:0]    level_left,
  input  wire logic [ADC_BITS+7:0]    level_right,
  input  wire otm_pkg::trip_cfg_t     cfg,
  output logic      [ADC_BITS+7:0]    filtered_left,
  output logic      [ADC_BITS+7:0]    filtered_right,
  output logic                        over_limit,
  output logic      [COUNT_BITS-1:0]  violation_count,
  output logic                        shutdown
);

  localparam int LW = ADC_BITS + 8;
  localparam int SW = LW + 1;
  localparam int CW = (SW > otm_pkg::LIMIT_BITS) ? SW : otm_pkg::LIMIT_BITS;
  localparam int TW = (COUNT_BITS > otm_pkg::THRESH_BITS) ? COUNT_BITS
                                                         : otm_pkg::THRESH_BITS;

  logic [SW-1:0]         level_sum;
  logic                  over_next;
  logic [TW-1:0]         thr_raw;
  logic [TW-1:0]         count_max;
  logic [TW-1:0]         thr_wide;
  logic [COUNT_BITS-1:0] thr_cnt;
  logic [COUNT_BITS-1:0] count_next;
  logic                  shutdown_next;

  // Effective threshold: zero acts as one, and it never exceeds the counter.
  always_comb begin
    thr_raw   = (cfg.threshold == '0) ? TW'(1) : TW'(cfg.threshold);
    count_max = TW'({COUNT_BITS{1'b1}});
    thr_wide  = (thr_raw > count_max) ? count_max : thr_raw;
    thr_cnt   = thr_wide[COUNT_BITS-1:0];
  end

  // Limit check on the summed levels.
  always_comb begin
    level_sum = {1'b0, level_left} + {1'b0, level_right};
    over_next = CW'(level_sum) > CW'(cfg.limit);
  end

  // Up/down counter, floored at zero and held at the threshold.
  always_comb begin
    if (over_next) begin
      if (violation_count >= thr_cnt) begin
        count_next = thr_cnt;
      end else begin
        count_next = violation_count + 1'b1;
      end
    end else if (violation_count != '0) begin
      count_next = violation_count - 1'b1;
    end else begin
      count_next = violation_count;
    end
    shutdown_next = shutdown | (count_next >= thr_cnt);
  end

  // Counter and trip flag are state; cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      violation_count <= '0;
      shutdown        <= 1'b0;
    end else if (load) begin
      violation_count <= count_next;
      shutdown        <= shutdown_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      filtered_left  <= level_left;
      filtered_right <= level_right;
      over_limit     <= over_next;
    end
  end

  // Once tripped, only reset clears shutdown.
  a_shutdown_latched: assert property (@(posedge clk) disable iff (rst)
    !$fell(shutdown))
    else $error("shutdown cleared without reset");

  // The counter changes only when an item passes through.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(violation_count))
    else $error("violation counter changed without an item");

  // An over-limit item below the threshold counts up by exactly one.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    load && over_next && (violation_count < thr_cnt) |=>
      violation_count == $past(violation_count) + 1'b1)
    else $error("violation counter did not count up");

endmodule

`default_nettype wire

FILE: dv/overcurrent_trip_monitor_test.sv
// ----------------------------------------------------------------------------
// Overcurrent trip monitor regression
// Drives sample pairs through the valid/ready input channel and takes
// readings from the output channel. Both sides insert random idle gaps.
// A scoreboard keeps its own copy of the filter levels, the violation
// counter and the trip flag, and compares every reading field by field.
// A short directed sequence covers the register extremes and the corner
// cases of the counter. Randomized phases with fresh settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module overcurrent_trip_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADC_BITS     = otm_pkg::ADC_BITS_DEF;
  localparam int COUNT_BITS   = otm_pkg::COUNT_BITS_DEF;
  localparam int LEVEL_BITS   = ADC_BITS + 8;
  localparam int PIPE_LATENCY = 3;
  localparam int MAX_GAP      = 11;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_CYCLES   = 400000;

  // Index that decodes to no register; writes to it must be ignored.
  localparam logic [otm_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam logic [ADC_BITS-1:0] SAMPLE_MAX = '1;

  // Fields of one output reading.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] left;
    logic [LEVEL_BITS-1:0] right;
    logic                  over;
    logic [COUNT_BITS-1:0] count;
    logic                  shut;
  } reading_t;

  // Sample distributions for the random phases.
  typedef enum int {
    MODE_UNIFORM,
    MODE_HIGH,
    MODE_LOW,
    MODE_EXTREME
  } sample_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the filter and trip state and holds the readings
  // that are still to come out of the block.
  // --------------------------------------------------------------------------
  class trip_scoreboard;
    logic [otm_pkg::ALPHA_BITS-1:0]  alpha;
    logic [otm_pkg::LIMIT_BITS-1:0]  limit;
    logic [otm_pkg::THRESH_BITS-1:0] threshold;
    logic [LEVEL_BITS-1:0]           left_level;
    logic [LEVEL_BITS-1:0]           right_level;
    logic [COUNT_BITS-1:0]           count;
    logic                            tripped;
    reading_t                        expected_readings[$];
    int                              failures;

    function new();
      alpha       = otm_pkg::ALPHA_RESET;
      limit       = otm_pkg::LIMIT_RESET;
      threshold   = otm_pkg::THRESHOLD_RESET;
      left_level  = '0;
      right_level = '0;
      count       = '0;
      tripped     = 1'b0;
      failures    = 0;
    endfunction

    // Register write as seen on the configuration port.
    function void set_register(logic [otm_pkg::CFG_INDEX_BITS-1:0] index,
                               logic [otm_pkg::CFG_DATA_BITS-1:0] data);
      case (index)
        otm_pkg::REG_FILTER_ALPHA:   alpha = data[otm_pkg::ALPHA_BITS-1:0];
        otm_pkg::REG_CURRENT_LIMIT:  limit = data[otm_pkg::LIMIT_BITS-1:0];
        otm_pkg::REG_TRIP_THRESHOLD: threshold = data[otm_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // One exponential filter step; the shift truncates.
    function logic [LEVEL_BITS-1:0] smooth(logic [LEVEL_BITS-1:0] level,
                                           logic [ADC_BITS-1:0] sample,
                                           logic [otm_pkg::ALPHA_BITS-1:0] weight);
      longint unsigned w_new;
      longint unsigned w_old;
      longint unsigned acc;
      w_new = weight;
      w_old = longint'(otm_pkg::ALPHA_ONE) - w_new;
      acc = longint'(level) * w_old + (longint'(sample) << 8) * w_new;
      return acc[otm_pkg::ALPHA_FRAC +: LEVEL_BITS];
    endfunction

    // Accepted sample pair: advance the state and queue the reading.
    function void note_samples(logic [ADC_BITS-1:0] left_sample,
                               logic [ADC_BITS-1:0] right_sample);
      logic [otm_pkg::ALPHA_BITS-1:0]  weight;
      logic [otm_pkg::THRESH_BITS-1:0] thr;
      logic                            over;
      reading_t                        exp_reading;
      weight = (alpha > otm_pkg::ALPHA_ONE) ? otm_pkg::ALPHA_ONE : alpha;
      thr = (threshold == 0) ? otm_pkg::THRESH_BITS'(1) : threshold;
      left_level  = smooth(left_level, left_sample, weight);
      right_level = smooth(right_level, right_sample, weight);
      over = (int'(left_level) + int'(right_level)) > int'(limit);
      // Up/down counter, clamped at zero and at the threshold.
      if (over) begin
        if (count >= thr) begin
          count = thr;
        end else begin
          count = count + 1'b1;
        end
      end else if (count > 0) begin
        count = count - 1'b1;
      end
      if (count >= thr) begin
        tripped = 1'b1;
      end
      exp_reading.left  = left_level;
      exp_reading.right = right_level;
      exp_reading.over  = over;
      exp_reading.count = count;
      exp_reading.shut  = tripped;
      expected_readings.push_back(exp_reading);
    endfunction

    // Compare one reading from the block with the oldest expected one.
    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("reading with no item outstanding");
        failures++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.left !== want.left) begin
        $error("filtered_left: expected %0d, actual %0d", want.left, got.left);
        failures++;
      end
      if (got.right !== want.right) begin
        $error("filtered_right: expected %0d, actual %0d", want.right, got.right);
        failures++;
      end
      if (got.over !== want.over) begin
        $error("over_limit: expected %0d, actual %0d", want.over, got.over);
        failures++;
      end
      if (got.count !== want.count) begin
        $error("violation_count: expected %0d, actual %0d", want.count, got.count);
        failures++;
      end
      if (got.shut !== want.shut) begin
        $error("shutdown: expected %0d, actual %0d", want.shut, got.shut);
        failures++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_write;
  logic [otm_pkg::CFG_INDEX_BITS-1:0]   cfg_index;
  logic [otm_pkg::CFG_DATA_BITS-1:0]    cfg_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [ADC_BITS-1:0]                  sample_left;
  logic [ADC_BITS-1:0]                  sample_right;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [LEVEL_BITS-1:0]                filtered_left;
  logic [LEVEL_BITS-1:0]                filtered_right;
  logic                                 over_limit;
  logic [COUNT_BITS-1:0]                violation_count;
  logic                                 shutdown;

  trip_scoreboard sb = new();
  bit             in_no_idle = 1'b0;
  bit             out_no_idle = 1'b0;
  int             cycles = 0;

  overcurrent_trip_monitor #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_left     (sample_left),
    .sample_right    (sample_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_left   (filtered_left),
    .filtered_right  (filtered_right),
    .over_limit      (over_limit),
    .violation_count (violation_count),
    .shutdown        (shutdown)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("overcurrent_trip_monitor regression: fail");
      $finish;
    end
  end

  // Observe register writes, accepted items and readings at the rising edge.
  always @(posedge clk) begin
    reading_t got;
    if (!rst) begin
      if (cfg_write) begin
        sb.set_register(cfg_index, cfg_data);
      end
      if (out_valid && out_ready) begin
        got.left  = filtered_left;
        got.right = filtered_right;
        got.over  = over_limit;
        got.count = violation_count;
        got.shut  = shutdown;
        sb.check_reading(got);
      end
      if (in_valid && in_ready) begin
        sb.note_samples(sample_left, sample_right);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks; each is entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one sample pair after a random gap and hold it until accepted.
  task automatic send_pair(input logic [ADC_BITS-1:0] left_sample,
                           input logic [ADC_BITS-1:0] right_sample);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_left  <= left_sample;
    sample_right <= right_sample;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop sending and wait until the block has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // One register write on the configuration port.
  task automatic write_register(input logic [otm_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [otm_pkg::CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample(sample_mode_t mode);
    case (mode)
      MODE_HIGH:    return ADC_BITS'($urandom_range(768, 1023));
      MODE_LOW:     return ADC_BITS'($urandom_range(0, 255));
      MODE_EXTREME: return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
      default:      return ADC_BITS'($urandom());
    endcase
  endfunction

  // Output side: hold ready low for a random gap before taking each reading.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      gap = out_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int           random_done;
    int           n;
    int           pick;
    int           which;
    sample_mode_t mode;
    logic [otm_pkg::ALPHA_BITS-1:0]  alpha_val;
    logic [otm_pkg::LIMIT_BITS-1:0]  limit_val;
    logic [otm_pkg::THRESH_BITS-1:0] thr_val;

    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    sample_left  = '0;
    sample_right = '0;
    random_done  = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default settings, field extremes and alternating bit patterns.
    send_pair('0, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, '0);
    send_pair('0, SAMPLE_MAX);
    send_pair(10'h2AA, 10'h155);
    send_pair(10'h155, 10'h2AA);

    // Weight of one: the filter follows the sample exactly.
    settle();
    write_register(otm_pkg::REG_FILTER_ALPHA,
                   otm_pkg::CFG_DATA_BITS'(otm_pkg::ALPHA_ONE));
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);

    // Weight above one acts as one.
    settle();
    write_register(otm_pkg::REG_FILTER_ALPHA, 19'h1FFF);
    send_pair(10'd512, 10'd700);

    // Largest limit: even full-scale samples stay under it.
    settle();
    write_register(otm_pkg::REG_CURRENT_LIMIT, 19'h7FFFF);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);

    // Zero limit: a zero sum is not over, anything else is.
    settle();
    write_register(otm_pkg::REG_CURRENT_LIMIT, '0);
    send_pair('0, '0);
    send_pair(10'd1, '0);
    send_pair('0, 10'd1);
    send_pair(10'd3, 10'd3);

    // Threshold lowered below the counter, then a zero threshold.
    settle();
    write_register(otm_pkg::REG_TRIP_THRESHOLD, 19'd2);
    send_pair('0, '0);
    send_pair(10'd5, 10'd5);
    settle();
    write_register(otm_pkg::REG_TRIP_THRESHOLD, '0);
    send_pair(10'd7, 10'd7);
    send_pair('0, '0);
    send_pair(10'd9, 10'd9);

    // Zero weight: the filter holds its level; the index with no register.
    settle();
    write_register(otm_pkg::REG_FILTER_ALPHA, '0);
    write_register(REG_UNUSED, 19'h7FFFF);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);

    // Random phases, each with its own settings and sample distribution.
    while (random_done < RANDOM_ITEMS) begin
      settle();
      which = $urandom_range(1, 7);
      if (which[0]) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       alpha_val = '0;
          1:       alpha_val = otm_pkg::ALPHA_ONE;
          2:       alpha_val = otm_pkg::ALPHA_BITS'($urandom_range(4097, 8191));
          3:       alpha_val = otm_pkg::ALPHA_BITS'($urandom());
          default: alpha_val = otm_pkg::ALPHA_BITS'($urandom_range(100, 4096));
        endcase
        // Bits above the register width must be dropped.
        write_register(otm_pkg::REG_FILTER_ALPHA,
                       {6'($urandom()), alpha_val});
      end
      if (which[1]) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0:       limit_val = '0;
          1:       limit_val = '1;
          2:       limit_val = otm_pkg::LIMIT_RESET;
          default: limit_val = otm_pkg::LIMIT_BITS'($urandom());
        endcase
        write_register(otm_pkg::REG_CURRENT_LIMIT, limit_val);
      end
      if (which[2]) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       thr_val = '0;
          1:       thr_val = '1;
          2:       thr_val = otm_pkg::THRESH_BITS'($urandom());
          default: thr_val = otm_pkg::THRESH_BITS'($urandom_range(1, 30));
        endcase
        write_register(otm_pkg::REG_TRIP_THRESHOLD, {3'($urandom()), thr_val});
      end
      if ($urandom_range(0, 15) == 0) begin
        write_register(REG_UNUSED, otm_pkg::CFG_DATA_BITS'($urandom()));
      end

      mode        = sample_mode_t'($urandom_range(0, 3));
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 120);
      repeat (n) begin
        send_pair(pick_sample(mode), pick_sample(mode));
      end
      random_done += n;
    end

    // Drain and let the pipeline run empty before the verdict.
    settle();
    repeat (PIPE_LATENCY * 4) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("overcurrent_trip_monitor regression: pass");
    end else begin
      $display("overcurrent_trip_monitor regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
